// ===== rtl/core/mlbm_pkg.sv =====
// Shared types, codes and level arithmetic for the multilevel byte symbol mapper.
// Used by every module of the block; depends on nothing.

package mlbm_pkg;

  // Operation codes carried on the input channel.
  localparam logic OP_EXPAND = 1'b0;
  localparam logic OP_SHRINK = 1'b1;

  // Parts-per-byte register codes; only these three are legal.
  localparam logic [2:0] PARTS_ONE  = 3'd1;
  localparam logic [2:0] PARTS_TWO  = 3'd2;
  localparam logic [2:0] PARTS_FOUR = 3'd4;
  localparam logic [2:0] PARTS_RESET = PARTS_TWO;

  // One result item as it travels to the output register.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       error;
  } mlbm_result_t;

  // True for a legal parts count.
  function automatic logic parts_ok(input logic [2:0] parts);
    return (parts == PARTS_ONE) || (parts == PARTS_TWO) || (parts == PARTS_FOUR);
  endfunction

  // Index of the final part of a byte for a legal parts count.
  function automatic logic [1:0] last_part(input logic [2:0] parts);
    logic [1:0] r;
    unique case (parts)
      PARTS_ONE:  r = 2'd0;
      PARTS_TWO:  r = 2'd1;
      PARTS_FOUR: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // Level for a part index. With eight bits per part the top level saturates.
  function automatic logic [7:0] level_of(input logic [7:0] idx, input logic [2:0] parts);
    logic [7:0] r;
    unique case (parts)
      PARTS_ONE:  r = (idx == 8'hFF) ? 8'hFF : idx + 8'd1;
      PARTS_TWO:  r = {idx[3:0], 1'b1, 3'b000};
      PARTS_FOUR: r = {idx[1:0], 1'b1, 5'b00000};
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  // Nearest level index for a received sample; ties resolve to the lower index.
  function automatic logic [7:0] nearest_index(input logic [7:0] s, input logic [2:0] parts);
    logic [7:0] dec;
    logic [7:0] r;
    dec = s - 8'd1;
    unique case (parts)
      PARTS_ONE:  r = dec;
      PARTS_TWO:  r = {4'b0000, dec[7:4]};
      PARTS_FOUR: r = {6'b000000, dec[7:6]};
      default:    r = 8'h00;
    endcase
    if (s == 8'h00) begin
      r = 8'h00;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mlbm_in_stage.sv =====
// Input register of the mapper: holds one accepted item, steps through its parts
// and keeps the shrink accumulator. Depends on mlbm_pkg.

module mlbm_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            parts_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [7:0]            sample_i,
  output logic                  res_valid_o,
  output mlbm_pkg::mlbm_result_t res_o,
  input  logic                  res_take_i
);
  import mlbm_pkg::*;

  logic       valid_q, valid_d;
  logic       op_q;
  logic [7:0] sample_q;
  logic [1:0] part_q, part_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] acc_q, acc_d;

  logic       p_ok, complete, has_out, final_part, done, accept;
  logic [1:0] p_last;
  logic [7:0] part_sel, shr_idx, acc_new;

  assign p_ok     = parts_ok(parts_i);
  assign p_last   = last_part(parts_i);
  assign complete = (idx_q >= p_last);

  // A shrink sample that does not complete a byte produces no result.
  assign has_out    = (op_q == OP_EXPAND) || !p_ok || complete;
  assign final_part = !p_ok || (op_q == OP_SHRINK) || (part_q == p_last);
  assign done       = valid_q && (!has_out || (res_take_i && final_part));
  assign in_stall_o = valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  // Select the current part of the data byte.
  always_comb begin
    part_sel = 8'h00;
    unique case (parts_i)
      PARTS_ONE:  part_sel = sample_q;
      PARTS_TWO:  part_sel = part_q[0] ? {4'b0000, sample_q[7:4]} : {4'b0000, sample_q[3:0]};
      PARTS_FOUR: begin
        case (part_q)
          2'd0:    part_sel = {6'b000000, sample_q[1:0]};
          2'd1:    part_sel = {6'b000000, sample_q[3:2]};
          2'd2:    part_sel = {6'b000000, sample_q[5:4]};
          default: part_sel = {6'b000000, sample_q[7:6]};
        endcase
      end
      default:    part_sel = 8'h00;
    endcase
  end

  // Place the recovered index at its part position; bits past bit 7 drop out.
  always_comb begin
    shr_idx = nearest_index(sample_q, parts_i);
    acc_new = acc_q;
    unique case (parts_i)
      PARTS_ONE:  acc_new = acc_q | ((idx_q == 2'd0) ? shr_idx : 8'h00);
      PARTS_TWO: begin
        case (idx_q)
          2'd0:    acc_new = acc_q | shr_idx;
          2'd1:    acc_new = acc_q | {shr_idx[3:0], 4'b0000};
          default: acc_new = acc_q;
        endcase
      end
      PARTS_FOUR: begin
        case (idx_q)
          2'd0:    acc_new = acc_q | shr_idx;
          2'd1:    acc_new = acc_q | {4'b0000, shr_idx[1:0], 2'b00};
          2'd2:    acc_new = acc_q | {2'b00, shr_idx[1:0], 4'b0000};
          default: acc_new = acc_q | {shr_idx[1:0], 6'b000000};
        endcase
      end
      default:    acc_new = acc_q;
    endcase
  end

  // Build the result offered to the output register.
  always_comb begin
    res_valid_o = valid_q && has_out;
    res_o.error = !p_ok;
    if (!p_ok) begin
      res_o.value = 8'h00;
      res_o.last  = 1'b1;
    end else if (op_q == OP_SHRINK) begin
      res_o.value = acc_new;
      res_o.last  = 1'b1;
    end else begin
      res_o.value = level_of(part_sel, parts_i);
      res_o.last  = (part_q == p_last);
    end
  end

  // Next state of the item register, part counter and shrink state.
  always_comb begin
    valid_d = valid_q;
    part_d  = part_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    if (accept) begin
      valid_d = 1'b1;
      part_d  = 2'd0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (res_valid_o && res_take_i) begin
      part_d = part_q + 2'd1;
    end
    if (done && (op_q == OP_SHRINK) && p_ok) begin
      if (complete) begin
        idx_d = 2'd0;
        acc_d = 8'h00;
      end else begin
        idx_d = idx_q + 2'd1;
        acc_d = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      part_q  <= 2'd0;
      idx_q   <= 2'd0;
      acc_q   <= 8'h00;
    end else begin
      valid_q <= valid_d;
      part_q  <= part_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
    end
  end

  // Payload of the accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      sample_q <= sample_i;
    end
  end

  // A freshly accepted item always starts at its first part.
  a_part_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (part_q == 2'd0))
    else $error("part counter not restarted on a new item");

  // Completing a byte clears the shrink state.
  a_shrink_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (op_q == OP_SHRINK) && p_ok && complete) |=> (idx_q == 2'd0) && (acc_q == 8'h00))
    else $error("shrink state not cleared after a full byte");

  // An empty input register never holds off the sender.
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> !in_stall_o)
    else $error("stall raised with no item held");

  // Error results always close their item.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.error) |-> res_o.last)
    else $error("error result not marked last");

endmodule

// ===== rtl/core/mlbm_out_reg.sv =====
// Output register of the mapper: holds one result until the receiver takes it.
// Depends on mlbm_pkg.

module mlbm_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  mlbm_pkg::mlbm_result_t res_i,
  output logic                   res_take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             value_o,
  output logic                   last_o,
  output logic                   error_o
);
  import mlbm_pkg::*;

  logic         valid_q, valid_d;
  mlbm_result_t res_q;

  // The register can load when empty or when its transfer completes now.
  assign res_take_o = !valid_q || !out_stall_i;
  assign valid_d    = res_take_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = res_q.value;
  assign last_o      = res_q.last;
  assign error_o     = res_q.error;

endmodule

// ===== rtl/core/multilevel_byte_symbol_mapper_unit.sv =====
// Top level of the multilevel byte symbol mapper: parts-count register, input
// stage and output register. Depends on mlbm_pkg, mlbm_in_stage and mlbm_out_reg.
//
// Usage:
// The input channel (in_valid_i / in_stall_o) carries op_i and sample_i. With
// op expand, one data byte becomes parts_per_byte level values, least
// significant part first, the final one marked by last_o. With op shrink, one
// received level is taken per transfer; after parts_per_byte samples one
// recovered byte leaves with last_o set. An illegal parts count yields one
// result with error_o set for any item.
// The output channel (out_valid_o / out_stall_i) moves one result per transfer.
// An accepted item waits in the input stage, and its result then moves into
// the output register. An expand item stays until all its parts are taken,
// one result per cycle unless the receiver stalls; a shrink item leaves once
// any result it gives is taken. The next item is accepted in the cycle its
// predecessor finishes. The parts count must be written through cfg_we_i /
// cfg_wdata_i only while idle; the block does not enforce this. Reset clears
// both registers, the shrink state, and sets the parts count to 2. When the
// receiver stalls, the output register holds its result and the input stage holds its item, then raises in_stall_o.

module multilevel_byte_symbol_mapper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] sample_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] value_o,
  output logic       last_o,
  output logic       error_o
);
  import mlbm_pkg::*;

  logic [2:0]   parts_q;
  logic         res_valid, res_take;
  mlbm_result_t res;

  // Parts-per-byte configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parts_q <= PARTS_RESET;
    end else if (cfg_we_i) begin
      parts_q <= cfg_wdata_i;
    end
  end

  mlbm_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .parts_i     (parts_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  mlbm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_take_o  (res_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule
